### rtl/sliding_log_rate_limiter_assert.svh
// ----------------------------------------------------------------------------
// Sliding log rate limiter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_LOG_RATE_LIMITER_ASSERT_SVH
`define SLIDING_LOG_RATE_LIMITER_ASSERT_SVH

// same-cycle implication
`define SLR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// Sliding log rate limiter package
// Field widths, reset values, codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int FLOW_IDX_W = 6;
  localparam int TIME_IN_W  = 32;
  localparam int WIN_W      = 31;
  localparam int LIM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int VERDICT_W  = 2;

  localparam int DEF_FLOW_COUNT = 64;
  localparam int DEF_LOG_DEPTH  = 64;
  localparam int DEF_TIME_BITS  = 32;

  localparam logic [WIN_W-1:0] RST_LONG_WIN  = 31'd60000;
  localparam logic [WIN_W-1:0] RST_SHORT_WIN = 31'd10000;
  localparam logic [LIM_W-1:0] RST_LONG_LIM  = 7'd60;
  localparam logic [LIM_W-1:0] RST_BURST_LIM = 7'd20;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_WIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LIM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LIM = 2'd3;

  localparam logic [VERDICT_W-1:0] VERDICT_OK    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_LONG  = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BURST = 2'd2;

  typedef struct packed {
    logic                 clr_step;
    logic                 load_item;
    logic                 reduce;
    logic                 ring_rd;
    logic                 ring_load;
    logic                 log_rd_head;
    logic                 pop;
    logic                 scan_init;
    logic                 log_rd_slot;
    logic                 scan_step;
    logic                 commit;
    logic                 append;
    logic                 res_load;
    logic [VERDICT_W-1:0] verdict;
  } slr_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic flow_ok;
    logic cnt_zero;
    logic expired;
    logic long_hit;
    logic scan_done;
    logic burst_hit;
    logic out_free;
  } slr_stat_t;

endpackage

### rtl/slr_if.sv
// ----------------------------------------------------------------------------
// Sliding log rate limiter channels
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface slr_req_if import slr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FLOW_IDX_W-1:0] flow_index;
  logic [TIME_IN_W-1:0]  time_now;
  modport source (output valid, flow_index, time_now, input ready);
  modport sink   (input valid, flow_index, time_now, output ready);
endinterface

interface slr_res_if import slr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 allowed;
  logic [VERDICT_W-1:0] verdict;
  modport source (output valid, allowed, verdict, input ready);
  modport sink   (input valid, allowed, verdict, output ready);
endinterface

interface slr_cfg_if import slr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/slr_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding log rate limiter controller
// Sequences clearing, flow reduction, ring fetch, pruning, burst scan, commit or append and result.
// ----------------------------------------------------------------------------
module slr_ctrl import slr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  slr_stat_t stat,
  output slr_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_REDUCE    = 4'd2;
  localparam logic [3:0] S_LOADR     = 4'd3;
  localparam logic [3:0] S_PRUNE_RD  = 4'd4;
  localparam logic [3:0] S_PRUNE_CMP = 4'd5;
  localparam logic [3:0] S_CHECK     = 4'd6;
  localparam logic [3:0] S_SCAN_RD   = 4'd7;
  localparam logic [3:0] S_SCAN_CMP  = 4'd8;
  localparam logic [3:0] S_DECIDE    = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  logic [3:0]           state_r, state_nxt;
  logic [VERDICT_W-1:0] verdict_r, verdict_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    verdict_nxt = verdict_r;
    cmd         = '0;
    cmd.verdict = verdict_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (stat.flow_ok) begin
          cmd.ring_rd = 1'b1;
          state_nxt   = S_LOADR;
        end else begin
          cmd.reduce = 1'b1;
        end
      end
      S_LOADR: begin
        cmd.ring_load = 1'b1;
        state_nxt     = S_PRUNE_RD;
      end
      S_PRUNE_RD: begin
        if (stat.cnt_zero) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.log_rd_head = 1'b1;
          state_nxt       = S_PRUNE_CMP;
        end
      end
      S_PRUNE_CMP: begin
        if (stat.expired) begin
          cmd.pop   = 1'b1;
          state_nxt = S_PRUNE_RD;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.long_hit) begin
          cmd.commit  = 1'b1;
          verdict_nxt = VERDICT_LONG;
          state_nxt   = S_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat.scan_done) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.log_rd_slot = 1'b1;
          state_nxt       = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd.scan_step = 1'b1;
        state_nxt     = S_SCAN_RD;
      end
      S_DECIDE: begin
        if (stat.burst_hit) begin
          cmd.commit  = 1'b1;
          verdict_nxt = VERDICT_BURST;
        end else begin
          cmd.append  = 1'b1;
          verdict_nxt = VERDICT_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      verdict_r <= VERDICT_OK;
    end else begin
      state_r   <= state_nxt;
      verdict_r <= verdict_nxt;
    end
  end

endmodule

### rtl/slr_dp.sv
// ----------------------------------------------------------------------------
// Sliding log rate limiter datapath
// Registers, ring state memory, timestamp log memory, age compares, result.
// ----------------------------------------------------------------------------
module slr_dp import slr_pkg::*; #(
  parameter int FLOW_COUNT = DEF_FLOW_COUNT,
  parameter int LOG_DEPTH  = DEF_LOG_DEPTH,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  slr_cmd_t              cmd,
  output slr_stat_t             stat,
  input  logic [FLOW_IDX_W-1:0] in_flow_index,
  input  logic [TIME_IN_W-1:0]  in_time_now,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_allowed,
  output logic [VERDICT_W-1:0]  out_verdict
);

`include "sliding_log_rate_limiter_assert.svh"

  localparam int FW = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
  localparam int HW = $clog2(LOG_DEPTH);
  localparam int NW = $clog2(LOG_DEPTH + 1);
  localparam int CW = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
  localparam int KW = (NW > LIM_W) ? NW : LIM_W;
  localparam int LOG_WORDS = FLOW_COUNT * (2 ** HW);

  logic [WIN_W-1:0] long_win_r, short_win_r;
  logic [LIM_W-1:0] long_lim_r, burst_lim_r;

  logic [FLOW_IDX_W-1:0] flow_r;
  logic [TIME_BITS-1:0]  now_r;
  logic [FW-1:0]         fa;
  logic [FW-1:0]         clr_addr_r;
  logic [HW-1:0]         head_r, slot_r, tail;
  logic [NW-1:0]         cnt_r, idx_r, recent_r;
  logic [HW+NW-1:0]      ring_q;
  logic [TIME_BITS-1:0]  log_q, age;
  logic [HW:0]           tail_sum;
  logic                  in_short;
  logic                  out_valid_r, out_allowed_r;
  logic [VERDICT_W-1:0]  out_verdict_r;

  logic [HW+NW-1:0]     ring_mem [FLOW_COUNT];
  logic [TIME_BITS-1:0] log_mem  [LOG_WORDS];

  function automatic logic [HW-1:0] wrap_inc(input logic [HW-1:0] v);
    wrap_inc = (v == HW'(LOG_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  assign fa       = FW'(flow_r);
  assign age      = now_r - log_q;
  assign in_short = CW'(age) <= CW'(short_win_r);
  assign tail_sum = {1'b0, head_r} + (HW+1)'(cnt_r);
  assign tail     = (tail_sum >= (HW+1)'(LOG_DEPTH)) ?
                    HW'(tail_sum - (HW+1)'(LOG_DEPTH)) : HW'(tail_sum);

  always_comb begin
    stat.clr_done  = (clr_addr_r == FW'(FLOW_COUNT - 1));
    stat.flow_ok   = int'(flow_r) < FLOW_COUNT;
    stat.cnt_zero  = (cnt_r == '0);
    stat.expired   = CW'(age) > CW'(long_win_r);
    stat.long_hit  = (KW'(cnt_r) >= KW'(long_lim_r)) || (cnt_r == NW'(LOG_DEPTH));
    stat.scan_done = (idx_r == cnt_r);
    stat.burst_hit = KW'(recent_r) >= KW'(burst_lim_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_win_r  <= RST_LONG_WIN;
      short_win_r <= RST_SHORT_WIN;
      long_lim_r  <= RST_LONG_LIM;
      burst_lim_r <= RST_BURST_LIM;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LONG_WIN:  long_win_r  <= cfg_data[WIN_W-1:0];
        REG_SHORT_WIN: short_win_r <= cfg_data[WIN_W-1:0];
        REG_LONG_LIM:  long_lim_r  <= cfg_data[LIM_W-1:0];
        REG_BURST_LIM: burst_lim_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step && !stat.clr_done) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      ring_mem[clr_addr_r] <= '0;
    end else if (cmd.commit) begin
      ring_mem[fa] <= {head_r, cnt_r};
    end else if (cmd.append) begin
      ring_mem[fa] <= {head_r, cnt_r + 1'b1};
    end
    if (cmd.ring_rd) begin
      ring_q <= ring_mem[fa];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      log_mem[{fa, tail}] <= now_r;
    end
    if (cmd.log_rd_head) begin
      log_q <= log_mem[{fa, head_r}];
    end else if (cmd.log_rd_slot) begin
      log_q <= log_mem[{fa, slot_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      flow_r <= in_flow_index;
      now_r  <= TIME_BITS'(in_time_now);
    end else if (cmd.reduce) begin
      flow_r <= flow_r - FLOW_IDX_W'(FLOW_COUNT);
    end
    if (cmd.ring_load) begin
      head_r <= ring_q[HW+NW-1:NW];
      cnt_r  <= ring_q[NW-1:0];
    end else if (cmd.pop) begin
      head_r <= wrap_inc(head_r);
      cnt_r  <= cnt_r - 1'b1;
    end
    if (cmd.scan_init) begin
      idx_r    <= '0;
      recent_r <= '0;
      slot_r   <= head_r;
    end else if (cmd.scan_step) begin
      idx_r    <= idx_r + 1'b1;
      slot_r   <= wrap_inc(slot_r);
      recent_r <= recent_r + NW'(in_short);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_allowed_r <= (cmd.verdict == VERDICT_OK);
      out_verdict_r <= cmd.verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_allowed = out_allowed_r;
  assign out_verdict = out_verdict_r;

  `SLR_ASSERT_IMP(a_pop_nonempty, cmd.pop, cnt_r != '0, "pop on empty ring")
  `SLR_ASSERT_IMP(a_append_room, cmd.append, !stat.long_hit && !stat.burst_hit,
                  "append past a limit")
  `SLR_ASSERT_IMP(a_no_overwrite, cmd.res_load, stat.out_free, "result overwritten")
  `SLR_ASSERT_NXT(a_result_shown, cmd.res_load, out_valid_r, "result not presented")

endmodule

### rtl/sliding_log_rate_limiter.sv
// ----------------------------------------------------------------------------
// Sliding log rate limiter
// Per-flow two-window sliding-log limiter with a long and a burst window.
// ----------------------------------------------------------------------------
// in_req carries flow_index and time_now; out_res returns allowed and verdict
// (0 accepted, 1 long limit, 2 burst limit), one result per request.
// cfg_wr writes the window and limit registers by index; it is always ready.
// A request's time from acceptance to result grows with P, the number of
// expired entries dropped, and C, the entries left to scan; each log entry
// costs one read of the timestamp memory and one compare.
// The limiter handles one request at a time.
// After reset the ring state memory is cleared, one flow per cycle, and
// in_req.ready stays low during that pass.
// The result sits in an output register: a new request is taken while it
// waits, and a stalled receiver only holds the next result in its last step.
// ----------------------------------------------------------------------------
module sliding_log_rate_limiter import slr_pkg::*; #(
  parameter int FLOW_COUNT = DEF_FLOW_COUNT,
  parameter int LOG_DEPTH  = DEF_LOG_DEPTH,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  slr_req_if.sink    in_req,
  slr_res_if.source  out_res,
  slr_cfg_if.sink    cfg_wr
);

  slr_cmd_t  cmd;
  slr_stat_t stat;

  assign cfg_wr.ready = 1'b1;

  slr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slr_dp #(
    .FLOW_COUNT (FLOW_COUNT),
    .LOG_DEPTH  (LOG_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_flow_index (in_req.flow_index),
    .in_time_now   (in_req.time_now),
    .cfg_valid     (cfg_wr.valid),
    .cfg_index     (cfg_wr.index),
    .cfg_data      (cfg_wr.data),
    .out_valid     (out_res.valid),
    .out_ready     (out_res.ready),
    .out_allowed   (out_res.allowed),
    .out_verdict   (out_res.verdict)
  );

endmodule
